>>> sv/tilt_compensated_euler_angles_top_macros.svh
// ----------------------------------------------------------------------------
// tilt compensated euler angles: assertion macros
// shared concurrent checks, each written as one labeled assertion
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_EULER_ANGLES_TOP_MACROS_SVH
`define TILT_COMPENSATED_EULER_ANGLES_TOP_MACROS_SVH

// condition on one edge implies a consequence on the same edge
`define TCEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold outside reset
`define TCEA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> sv/tcea_pkg.sv
// ----------------------------------------------------------------------------
// tcea_pkg
// shared types, fixed formats and the cordic arctangent table
// ----------------------------------------------------------------------------
package tcea_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int GUARD_BITS   = 8;
  // q30 radian angles inside the cordic units
  localparam int ZW           = 34;

  localparam logic signed [ZW-1:0] Q30_PI       = 34'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI  = 34'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_INV_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
    logic signed [SAMPLE_WIDTH-1:0] mag_x;
    logic signed [SAMPLE_WIDTH-1:0] mag_y;
    logic signed [SAMPLE_WIDTH-1:0] mag_z;
  } in_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  } out_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      5'd30: v = 34'sd1;
      5'd31: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/tcea_vec.sv
// ----------------------------------------------------------------------------
// tcea_vec
// pipelined vectoring cordic: atan2(y, x) rounded to the output angle format
// ----------------------------------------------------------------------------
module tcea_vec #(
  parameter int W      = 20,
  parameter int STEPS  = 16,
  parameter int FRAC   = 13,
  parameter int SIDE_W = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [W-1:0]                  in_x,
  input  logic signed [W-1:0]                  in_y,
  input  logic [SIDE_W-1:0]                    in_side,
  output logic                                 out_valid,
  output logic signed [tcea_pkg::ANGLE_WIDTH-1:0] out_angle,
  output logic [SIDE_W-1:0]                    out_side
);

  localparam int ZW = tcea_pkg::ZW;
  localparam int SH = 30 - FRAC;
  localparam logic signed [ZW-1:0] SAT_HI = ZW'(32767);
  localparam logic signed [ZW-1:0] SAT_LO = -ZW'(32768);

  logic                 v_r    [0:STEPS];
  logic signed [W-1:0]  x_r    [0:STEPS];
  logic signed [W-1:0]  y_r    [0:STEPS];
  logic signed [ZW-1:0] z_r    [0:STEPS];
  logic                 zero_r [0:STEPS];
  logic [SIDE_W-1:0]    side_r [0:STEPS];

  logic signed [W-1:0]  x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;
  logic signed [ZW-1:0] rnd_nxt, shv_nxt;
  logic signed [tcea_pkg::ANGLE_WIDTH-1:0] ang_nxt;
  logic                 valid_r;
  logic signed [tcea_pkg::ANGLE_WIDTH-1:0] angle_r;
  logic [SIDE_W-1:0]    oside_r;

  // fold the left half plane onto the right one
  always_comb begin
    if (in_x[W-1]) begin
      x0_nxt = -in_x;
      y0_nxt = -in_y;
      z0_nxt = in_y[W-1] ? -tcea_pkg::Q30_PI : tcea_pkg::Q30_PI;
    end else begin
      x0_nxt = in_x;
      y0_nxt = in_y;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= x0_nxt;
    y_r[0]    <= y0_nxt;
    z_r[0]    <= z0_nxt;
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    side_r[0] <= in_side;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [W-1:0]  x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      if (!y_r[i][W-1] && (y_r[i] != '0)) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + tcea_pkg::atan_q30(5'(i));
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - tcea_pkg::atan_q30(5'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      x_r[i+1]    <= x_nxt;
      y_r[i+1]    <= y_nxt;
      z_r[i+1]    <= z_nxt;
      zero_r[i+1] <= zero_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  // round half up, saturate, force zero vector to zero
  always_comb begin
    rnd_nxt = z_r[STEPS] + (ZW'(1) <<< (SH - 1));
    shv_nxt = rnd_nxt >>> SH;
    if (zero_r[STEPS]) begin
      ang_nxt = '0;
    end else if (shv_nxt > SAT_HI) begin
      ang_nxt = SAT_HI[tcea_pkg::ANGLE_WIDTH-1:0];
    end else if (shv_nxt < SAT_LO) begin
      ang_nxt = SAT_LO[tcea_pkg::ANGLE_WIDTH-1:0];
    end else begin
      ang_nxt = shv_nxt[tcea_pkg::ANGLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= ang_nxt;
    oside_r <= side_r[STEPS];
  end

  assign out_valid = valid_r;
  assign out_angle = angle_r;
  assign out_side  = oside_r;

endmodule

>>> sv/tcea_rot.sv
// ----------------------------------------------------------------------------
// tcea_rot
// pipelined rotation cordic: q30 cosine and sine of an output-format angle
// ----------------------------------------------------------------------------
module tcea_rot #(
  parameter int STEPS  = 16,
  parameter int FRAC   = 13,
  parameter int SIDE_W = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [tcea_pkg::ANGLE_WIDTH-1:0] in_angle,
  input  logic [SIDE_W-1:0]                    in_side,
  output logic                                 out_valid,
  output logic signed [31:0]                   out_cos,
  output logic signed [31:0]                   out_sin,
  output logic [SIDE_W-1:0]                    out_side
);

  localparam int ZW = tcea_pkg::ZW;
  localparam int SH = 30 - FRAC;

  logic                 v_r    [0:STEPS];
  logic signed [ZW-1:0] x_r    [0:STEPS];
  logic signed [ZW-1:0] y_r    [0:STEPS];
  logic signed [ZW-1:0] a_r    [0:STEPS];
  logic                 flip_r [0:STEPS];
  logic [SIDE_W-1:0]    side_r [0:STEPS];

  logic signed [ZW-1:0] a_in, a0_nxt;
  logic                 flip_nxt;
  logic signed [ZW-1:0] c_nxt, s_nxt;
  logic                 valid_r;
  logic signed [31:0]   cos_r, sin_r;
  logic [SIDE_W-1:0]    oside_r;

  // to q30, then move angles beyond a quarter turn by pi
  always_comb begin
    a_in = ZW'(in_angle) <<< SH;
    if (a_in > tcea_pkg::Q30_HALF_PI) begin
      a0_nxt   = a_in - tcea_pkg::Q30_PI;
      flip_nxt = 1'b1;
    end else if (a_in < -tcea_pkg::Q30_HALF_PI) begin
      a0_nxt   = a_in + tcea_pkg::Q30_PI;
      flip_nxt = 1'b1;
    end else begin
      a0_nxt   = a_in;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= tcea_pkg::Q30_INV_GAIN;
    y_r[0]    <= '0;
    a_r[0]    <= a0_nxt;
    flip_r[0] <= flip_nxt;
    side_r[0] <= in_side;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [ZW-1:0] x_nxt, y_nxt, a_nxt;

    always_comb begin
      if (!a_r[i][ZW-1]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        a_nxt = a_r[i] - tcea_pkg::atan_q30(5'(i));
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        a_nxt = a_r[i] + tcea_pkg::atan_q30(5'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      x_r[i+1]    <= x_nxt;
      y_r[i+1]    <= y_nxt;
      a_r[i+1]    <= a_nxt;
      flip_r[i+1] <= flip_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  // undo the half-turn move
  always_comb begin
    c_nxt = flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
    s_nxt = flip_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    cos_r   <= c_nxt[31:0];
    sin_r   <= s_nxt[31:0];
    oside_r <= side_r[STEPS];
  end

  assign out_valid = valid_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;
  assign out_side  = oside_r;

endmodule

>>> sv/tilt_compensated_euler_angles_top.sv
// ----------------------------------------------------------------------------
// tilt_compensated_euler_angles_top
// Takes one accelerometer and one magnetometer sample per beat and returns
// roll, pitch and tilt compensated yaw in signed radians with ANGLE_FRAC_BITS
// fraction bits. The block is a straight pipeline: busy never rises, a new
// beat is taken in every cycle, and each result appears on out_data with
// out_valid high for one cycle exactly. The path runs through the 24-stage
// square root ahead of the roll arctangent, the three chained cordic units
// (arctangent, sine/cosine, heading arctangent) of one stage per step, and
// four multiply stages for the rotated magnetometer vector. The block keeps
// no state between beats and results cannot be held off.
// ----------------------------------------------------------------------------
`include "tilt_compensated_euler_angles_top_macros.svh"

module tilt_compensated_euler_angles_top #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tcea_pkg::in_t  in_data,
  output logic           out_valid,
  output tcea_pkg::out_t out_data
);

  localparam int SW  = tcea_pkg::SAMPLE_WIDTH;
  localparam int AW  = tcea_pkg::ANGLE_WIDTH;
  localparam int GB  = tcea_pkg::GUARD_BITS;
  localparam int NV  = 2 * SW + 2 * GB;
  localparam int RB  = NV / 2;
  localparam int RW  = RB + 3;
  localparam int W_R = RB + 4;
  localparam int W_P = SW + 3;
  localparam int W_Y = SW + 35;
  localparam int LAT = 2 + RB + 3 * (CORDIC_STEPS + 2) + 4;
  localparam int SH  = 30 - ANGLE_FRAC_BITS;
  localparam longint PI_OUT = (64'sd3373259426 + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam logic signed [AW-1:0] ANG_LIM = (PI_OUT > 32767) ? 16'sd32767 : AW'(PI_OUT);

  // square stage
  logic             a_v_r;
  tcea_pkg::in_t    a_in_r;
  logic [2*SW-1:0]  ay2_r, az2_r;

  // square root stages
  logic             q_v_r    [0:RB];
  tcea_pkg::in_t    q_in_r   [0:RB];
  logic [NV-1:0]    q_op_r   [0:RB];
  logic [RW-1:0]    q_rem_r  [0:RB];
  logic [RB-1:0]    q_root_r [0:RB];

  // arctangent outputs
  logic                    roll_v, pitch_v;
  logic signed [AW-1:0]    roll_ang, pitch_ang;
  logic [2*SW-1:0]         roll_side;
  logic [SW-1:0]           pitch_side;
  logic signed [W_R-1:0]   roll_x, roll_y;
  logic signed [W_P-1:0]   pitch_x, pitch_y;

  // sine/cosine outputs
  logic                    rr_v, pr_v;
  logic signed [31:0]      cr, sr, cp, sp;
  logic [3*SW-1:0]         rr_side;
  logic [2*AW-1:0]         pr_side;

  // rotated magnetometer stages
  logic                    p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic [2*AW-1:0]         p1_ang_r, p2_ang_r, p3_ang_r, p4_ang_r;
  logic signed [SW-1:0]    p1_mx_r, p1_mz_r, p2_mx_r, p2_mz_r;
  logic signed [SW+31:0]   p1_mxcp_r, p1_mzsp_r, p1_mycr_r, p2_mycr_r, p3_mycr_r;
  logic signed [63:0]      p1_srsp_r, p1_srcp_r;
  logic signed [W_Y-1:0]   p2_mx2_r, p3_mx2_r, p4_mx2_r, p4_ny_r;
  logic signed [31:0]      p2_s1_r, p2_s2_r;
  logic signed [SW+31:0]   p3_mxs_r, p3_mzs_r;

  // heading outputs
  logic                    yaw_v;
  logic signed [AW-1:0]    yaw_ang;
  logic [2*AW-1:0]         yaw_side;

  assign busy = 1'b0;

  // square of the y and z accel axes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_in_r <= in_data;
    ay2_r  <= $unsigned((2*SW)'(in_data.accel_y * in_data.accel_y));
    az2_r  <= $unsigned((2*SW)'(in_data.accel_z * in_data.accel_z));
  end

  // square root operand with guard bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r[0] <= 1'b0;
    end else begin
      q_v_r[0] <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    q_in_r[0]   <= a_in_r;
    q_op_r[0]   <= {ay2_r + az2_r, (2*GB)'(0)};
    q_rem_r[0]  <= '0;
    q_root_r[0] <= '0;
  end

  // floor square root, one result bit per stage
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [RW-1:0] rem2_nxt, trial_nxt, rem_nxt;
    logic [RB-1:0] root_nxt;

    always_comb begin
      rem2_nxt  = {q_rem_r[k][RW-3:0], q_op_r[k][NV-1:NV-2]};
      trial_nxt = RW'({q_root_r[k], 2'b01});
      if (rem2_nxt >= trial_nxt) begin
        rem_nxt  = rem2_nxt - trial_nxt;
        root_nxt = {q_root_r[k][RB-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2_nxt;
        root_nxt = {q_root_r[k][RB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_v_r[k+1] <= 1'b0;
      end else begin
        q_v_r[k+1] <= q_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      q_in_r[k+1]   <= q_in_r[k];
      q_op_r[k+1]   <= q_op_r[k] << 2;
      q_rem_r[k+1]  <= rem_nxt;
      q_root_r[k+1] <= root_nxt;
    end
  end

  // roll and pitch arctangents side by side
  assign roll_x  = W_R'($signed({1'b0, q_root_r[RB]}));
  assign roll_y  = -(W_R'(q_in_r[RB].accel_x) <<< GB);
  assign pitch_x = W_P'(q_in_r[RB].accel_z);
  assign pitch_y = W_P'(q_in_r[RB].accel_y);

  tcea_vec #(
    .W(W_R), .STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS), .SIDE_W(2*SW)
  ) u_roll_vec (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q_v_r[RB]), .in_x(roll_x), .in_y(roll_y),
    .in_side({q_in_r[RB].mag_x, q_in_r[RB].mag_y}),
    .out_valid(roll_v), .out_angle(roll_ang), .out_side(roll_side)
  );

  tcea_vec #(
    .W(W_P), .STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS), .SIDE_W(SW)
  ) u_pitch_vec (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q_v_r[RB]), .in_x(pitch_x), .in_y(pitch_y),
    .in_side(q_in_r[RB].mag_z),
    .out_valid(pitch_v), .out_angle(pitch_ang), .out_side(pitch_side)
  );

  // sine and cosine of the rounded angles
  tcea_rot #(
    .STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS), .SIDE_W(3*SW)
  ) u_roll_rot (
    .clk(clk), .rst_n(rst_n),
    .in_valid(roll_v && pitch_v), .in_angle(roll_ang),
    .in_side({roll_side, pitch_side}),
    .out_valid(rr_v), .out_cos(cr), .out_sin(sr), .out_side(rr_side)
  );

  tcea_rot #(
    .STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS), .SIDE_W(2*AW)
  ) u_pitch_rot (
    .clk(clk), .rst_n(rst_n),
    .in_valid(roll_v && pitch_v), .in_angle(pitch_ang),
    .in_side({roll_ang, pitch_ang}),
    .out_valid(pr_v), .out_cos(cp), .out_sin(sp), .out_side(pr_side)
  );

  // valid bits of the product stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else begin
      p1_v_r <= rr_v && pr_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
  end

  // first products of the tilt rotation
  always_ff @(posedge clk) begin
    p1_ang_r  <= pr_side;
    p1_mx_r   <= $signed(rr_side[3*SW-1:2*SW]);
    p1_mz_r   <= $signed(rr_side[SW-1:0]);
    p1_mxcp_r <= $signed(rr_side[3*SW-1:2*SW]) * cp;
    p1_mzsp_r <= $signed(rr_side[SW-1:0]) * sp;
    p1_mycr_r <= $signed(rr_side[2*SW-1:SW]) * cr;
    p1_srsp_r <= sr * sp;
    p1_srcp_r <= sr * cp;
  end

  // mx2 and the q30 sine products
  always_ff @(posedge clk) begin
    p2_ang_r  <= p1_ang_r;
    p2_mx_r   <= p1_mx_r;
    p2_mz_r   <= p1_mz_r;
    p2_mycr_r <= p1_mycr_r;
    p2_mx2_r  <= W_Y'(p1_mxcp_r) - W_Y'(p1_mzsp_r);
    p2_s1_r   <= $signed(p1_srsp_r[61:30]);
    p2_s2_r   <= $signed(p1_srcp_r[61:30]);
  end

  // second products
  always_ff @(posedge clk) begin
    p3_ang_r  <= p2_ang_r;
    p3_mycr_r <= p2_mycr_r;
    p3_mx2_r  <= p2_mx2_r;
    p3_mxs_r  <= p2_mx_r * p2_s1_r;
    p3_mzs_r  <= p2_mz_r * p2_s2_r;
  end

  // my2, negated for the heading
  always_ff @(posedge clk) begin
    p4_ang_r <= p3_ang_r;
    p4_mx2_r <= p3_mx2_r;
    p4_ny_r  <= -(W_Y'(p3_mxs_r) + W_Y'(p3_mycr_r) + W_Y'(p3_mzs_r));
  end

  // heading arctangent
  tcea_vec #(
    .W(W_Y), .STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS), .SIDE_W(2*AW)
  ) u_yaw_vec (
    .clk(clk), .rst_n(rst_n),
    .in_valid(p4_v_r), .in_x(p4_mx2_r), .in_y(p4_ny_r),
    .in_side(p4_ang_r),
    .out_valid(yaw_v), .out_angle(yaw_ang), .out_side(yaw_side)
  );

  assign out_valid            = yaw_v;
  assign out_data.roll_angle  = $signed(yaw_side[2*AW-1:AW]);
  assign out_data.pitch_angle = $signed(yaw_side[AW-1:0]);
  assign out_data.yaw_angle   = yaw_ang;

  // checks
  `TCEA_ASSERT_IMPL(a_latency, clk, rst_n, out_valid, $past(start, LAT), "result without a start beat")
  `TCEA_ASSERT_IMPL(a_roll_range, clk, rst_n, out_valid, (out_data.roll_angle >= -ANG_LIM) && (out_data.roll_angle <= ANG_LIM), "roll beyond pi")
  `TCEA_ASSERT_NEVER(a_no_busy, clk, rst_n, busy, "busy raised")

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench for tilt_compensated_euler_angles_top
// drives accelerometer and magnetometer samples, predicts roll, pitch and
// tilt compensated yaw with a bit-exact fixed-point cordic model, and checks
// each output beat against the oldest predicted angle triple
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS     = 16;
  localparam int FRAC      = 13;
  localparam int LATENCY   = 84;
  localparam int MAX_CYCLE = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  tcea_pkg::in_t  in_data;
  logic out_valid;
  tcea_pkg::out_t out_data;

  tcea_pkg::in_t  sample_q[$];
  tcea_pkg::out_t angle_q[$];
  int      phase_gap;
  bit      stim_done;
  bit      failed;
  longint  cycle_cnt;

  tilt_compensated_euler_angles_top #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_FRAC_BITS(FRAC)
  ) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // arctangent table entries in q30
  function automatic longint atan_entry(int i);
    longint t[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                      524288, 262144, 131072, 65536, 32768};
    return t[i];
  endfunction

  // floor square root
  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned op, res, one;
    op = v;
    res = 0;
    one = 64'd1 << 62;
    while (one > op) one >>= 2;
    while (one != 0) begin
      if (op >= res + one) begin
        op -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring cordic, q30 angle rounded to the output format
  function automatic longint angle_of(longint y, longint x);
    longint z, nx, ny, r;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_entry(i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_entry(i);
      end
      x = nx;
      y = ny;
    end
    r = (z + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // rotation cordic, q30 cosine and sine
  function automatic void cos_sin(input longint a, output longint c, output longint s);
    bit     flip;
    longint x, y, nx, ny;
    flip = 0;
    x = 652032874;
    y = 0;
    if (a > 64'sd1686629713) begin
      a -= 64'sd3373259426;
      flip = 1;
    end else if (a < -64'sd1686629713) begin
      a += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        a -= atan_entry(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        a += atan_entry(i);
      end
      x = nx;
      y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // euler angles of one sample pair
  function automatic tcea_pkg::out_t euler_angles(tcea_pkg::in_t s);
    longint ax, ay, az, mx, my, mz, r, roll, pitch, cr, sr, cp, sp, mx2, my2, yaw;
    tcea_pkg::out_t o;
    ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
    mx = s.mag_x;   my = s.mag_y;   mz = s.mag_z;
    r = floor_sqrt(longint'(ay * ay + az * az) << (2 * tcea_pkg::GUARD_BITS));
    roll = angle_of(-ax * (64'sd1 << tcea_pkg::GUARD_BITS), r);
    pitch = angle_of(ay, az);
    cos_sin(roll * (64'sd1 << (30 - FRAC)), cr, sr);
    cos_sin(pitch * (64'sd1 << (30 - FRAC)), cp, sp);
    mx2 = mx * cp - mz * sp;
    my2 = mx * ((sr * sp) >>> 30) + my * cr + mz * ((sr * cp) >>> 30);
    yaw = angle_of(-my2, mx2);
    o.roll_angle = roll[15:0];
    o.pitch_angle = pitch[15:0];
    o.yaw_angle = yaw[15:0];
    return o;
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus: directed extremes, then random phases
  initial begin
    tcea_pkg::in_t s;
    logic [15:0] ext[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    phase_gap = 0;
    stim_done = 0;
    // zero vectors, axis cases and both half planes
    sample_q.push_back('0);
    for (int i = 0; i < 5; i++) begin
      s = {ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5],
           ext[(i + 3) % 5], ext[(i + 4) % 5], ext[i]};
      sample_q.push_back(s);
      s = {16'h0000, 16'h0000, 16'h0000, ext[i], ext[(i + 2) % 5], ext[i]};
      sample_q.push_back(s);
      s = {ext[i], 16'h0000, 16'h0000, ext[(i + 1) % 5], 16'h0000, 16'h0000};
      sample_q.push_back(s);
      s = {16'h0000, ext[i], 16'h8000, 16'h8000, ext[i], 16'h7fff};
      sample_q.push_back(s);
    end
    for (int p = 0; p < 4; p++) begin
      wait (sample_q.size() == 0);
      phase_gap = (p == 1) ? 87 : ((p == 3) ? 13 : 0);
      for (int k = 0; k < 100; k++) begin
        s = {rand_field(), rand_field(), rand_field(),
             rand_field(), rand_field(), rand_field()};
        sample_q.push_back(s);
      end
    end
    stim_done = 1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) angle_q.push_back(euler_angles(in_data));
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= phase_gap) begin
        start <= 1'b1;
        in_data <= sample_q.pop_front();
      end else begin
        start <= 1'b0;
        in_data <= tcea_pkg::in_t'({$urandom, $urandom, $urandom});
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tcea_pkg::out_t e;
    if (rst_n && out_valid) begin
      if (angle_q.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1;
      end else begin
        e = angle_q.pop_front();
        if (out_data.roll_angle !== e.roll_angle) begin
          $error("roll_angle expected %0d actual %0d", e.roll_angle, out_data.roll_angle);
          failed = 1;
        end
        if (out_data.pitch_angle !== e.pitch_angle) begin
          $error("pitch_angle expected %0d actual %0d", e.pitch_angle,
                 out_data.pitch_angle);
          failed = 1;
        end
        if (out_data.yaw_angle !== e.yaw_angle) begin
          $error("yaw_angle expected %0d actual %0d", e.yaw_angle, out_data.yaw_angle);
          failed = 1;
        end
      end
    end
  end

  // reset, end of run and cycle limit
  initial begin
    failed = 0;
    cycle_cnt = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        #1;
        wait (stim_done && sample_q.size() == 0);
        @(posedge clk);
        while (start) @(posedge clk);
        @(posedge clk);
        while (angle_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
      end
      begin
        while (cycle_cnt < MAX_CYCLE) begin
          @(posedge clk);
          cycle_cnt++;
        end
        failed = 1;
      end
    join_any
    if (failed || angle_q.size() != 0) begin
      $display("end of test: mismatches");
    end else begin
      $display("end of test: clean");
    end
    $finish;
  end
endmodule
